### rtl/assert_macros.svh
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sgpa_pkg.sv
package sgpa_pkg;

    localparam int MAX_VERTICES = 65536;
    localparam int MAX_CLUSTERS = 64;

    localparam int VTX_W      = 16;
    localparam int CL_W       = 6;
    localparam int LBL_W      = CL_W + 1;
    localparam int CNT_W      = 16;
    localparam int SIZE_W     = 17;
    localparam int ALPHA_W    = 16;
    localparam int NC_W       = 7;
    localparam int FUNC_W     = 3;
    localparam int PROD_W     = ALPHA_W + SIZE_W;
    localparam int SCORE_W    = PROD_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 40;
    localparam int S_USER_W   = FUNC_W;
    localparam int M_DATA_W   = 8;
    localparam int M_USER_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_NEIGHBOUR    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DECIDE       = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEED         = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR_SIZES  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ_LABEL   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PASS   = 2'd2;

    localparam logic [NC_W-1:0]    NC_RESET    = 7'd2;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd256;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NB_LBL,
        ST_NB_CNT,
        ST_DEC_LBL,
        ST_SCAN_MUL,
        ST_SCAN_CMP,
        ST_DEC_WR,
        ST_SEED,
        ST_READ
    } state_t;

endpackage

### rtl/streaming_graph_partition_assign.sv
// A neighbour, decide, seed or label read word holds tready low until the block
// is idle again; clear sizes keeps it high. A label read result is registered
// from ST_READ. A decide scans the K active clusters in ST_SCAN_MUL, ST_SCAN_CMP
// with one shared score multiplier, then answers from ST_DEC_WR, or from
// ST_DEC_LBL when the first pass keeps a labelled vertex's existing label.
// Reset: async, active low; a clearing pass over all 65536 labels follows, tready low.
module streaming_graph_partition_assign
(
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata: vertex[15:0], neighbour[31:16], seed_cluster[37:32], zero pad
    input  logic [sgpa_pkg::S_DATA_W-1:0]      s_tdata,
    // s_tuser: func[2:0]
    input  logic [sgpa_pkg::S_USER_W-1:0]      s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: cluster[5:0], zero pad
    output logic [sgpa_pkg::M_DATA_W-1:0]      m_tdata,
    // m_tuser: assigned[0], skipped[1]
    output logic [sgpa_pkg::M_USER_W-1:0]      m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_we,
    input  logic [sgpa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sgpa_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sgpa_pkg::*;

    // Label memory: bit CL_W is the valid flag, the low bits the cluster.
    logic [LBL_W-1:0]  label_mem [MAX_VERTICES];
    // Per-cluster scratch counts and sizes; a clear valid bit reads as zero.
    logic [CNT_W-1:0]  cnt_mem   [MAX_CLUSTERS];
    logic [SIZE_W-1:0] size_mem  [MAX_CLUSTERS];

    state_t state_reg, state_next;

    logic [NC_W-1:0]         nc_reg;
    logic [ALPHA_W-1:0]      alpha_reg;
    logic                    first_pass_reg;

    logic [VTX_W-1:0]        clr_addr_reg, clr_addr_next;
    logic [VTX_W-1:0]        addr_reg, addr_next;
    logic [CL_W-1:0]         idx_reg, idx_next;
    logic [CL_W-1:0]         best_reg, best_next;
    logic signed [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [SIZE_W-1:0]       best_size_reg, best_size_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [CNT_W-1:0]        cnt_s_reg, cnt_s_next;
    logic [SIZE_W-1:0]       size_s_reg, size_s_next;
    logic [MAX_CLUSTERS-1:0] cnt_valid_reg, cnt_valid_next;
    logic [MAX_CLUSTERS-1:0] size_valid_reg, size_valid_next;

    logic                    out_valid_reg, out_valid_next;
    logic [CL_W-1:0]         out_cluster_reg, out_cluster_next;
    logic                    out_assigned_reg, out_assigned_next;
    logic                    out_skipped_reg, out_skipped_next;

    logic [LBL_W-1:0]        lbl_rd_reg;
    logic [CNT_W-1:0]        cnt_rd_reg;
    logic [SIZE_W-1:0]       size_rd_reg;

    logic                    lbl_we;
    logic [VTX_W-1:0]        lbl_waddr;
    logic [LBL_W-1:0]        lbl_wdata;
    logic                    cnt_we;
    logic [CNT_W-1:0]        cnt_wdata;
    logic                    size_we;
    logic [CL_W-1:0]         size_waddr;
    logic [SIZE_W-1:0]       size_wdata;

    logic [CNT_W-1:0]        cnt_eff;
    logic [SIZE_W-1:0]       size_eff;
    logic [CL_W-1:0]         k_last;
    logic                    out_free;
    logic signed [SCORE_W-1:0] score;

    logic [FUNC_W-1:0]       in_func;
    logic [VTX_W-1:0]        in_vertex;
    logic [VTX_W-1:0]        in_neighbour;
    logic [CL_W-1:0]         in_seed;

    assign in_func      = s_tuser;
    assign in_vertex    = s_tdata[VTX_W-1:0];
    assign in_neighbour = s_tdata[2*VTX_W-1:VTX_W];
    assign in_seed      = s_tdata[2*VTX_W+CL_W-1:2*VTX_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-CL_W){1'b0}}, out_cluster_reg};
    assign m_tuser  = {out_skipped_reg, out_assigned_reg};
    assign out_free = !out_valid_reg || m_tready;

    // Scratch entries whose valid bit is clear read as zero.
    assign cnt_eff  = cnt_valid_reg[idx_reg]  ? cnt_rd_reg  : '0;
    assign size_eff = size_valid_reg[idx_reg] ? size_rd_reg : '0;

    // Clamp the active cluster count to 1..MAX_CLUSTERS; hold the last index.
    always_comb
    begin
        if (nc_reg == '0)
            k_last = '0;
        else if (nc_reg > NC_W'(MAX_CLUSTERS))
            k_last = CL_W'(MAX_CLUSTERS - 1);
        else
            k_last = CL_W'(nc_reg - NC_W'(1));
    end

    // Score in signed Q26.8 (35 bits, 8 fraction bits): count*256 - alpha*size, exact.
    assign score = $signed({{(SCORE_W-CNT_W-8){1'b0}}, cnt_s_reg, 8'b0})
                 - $signed({{(SCORE_W-PROD_W){1'b0}}, prod_reg});

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg         <= NC_RESET;
            alpha_reg      <= ALPHA_RESET;
            first_pass_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_CLUSTERS: nc_reg         <= cfg_data[NC_W-1:0];
                CFG_ALPHA_Q:      alpha_reg      <= cfg_data[ALPHA_W-1:0];
                CFG_FIRST_PASS:   first_pass_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            cnt_valid_reg  <= '0;
            size_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            cnt_valid_reg  <= cnt_valid_next;
            size_valid_reg <= size_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers, no reset.
    always_ff @(posedge clk)
    begin
        addr_reg         <= addr_next;
        idx_reg          <= idx_next;
        best_reg         <= best_next;
        best_score_reg   <= best_score_next;
        best_size_reg    <= best_size_next;
        prod_reg         <= prod_next;
        cnt_s_reg        <= cnt_s_next;
        size_s_reg       <= size_s_next;
        out_cluster_reg  <= out_cluster_next;
        out_assigned_reg <= out_assigned_next;
        out_skipped_reg  <= out_skipped_next;
    end

    // Memories: one write port, one registered read port each. Reads follow
    // the next address so the data is there in the cycle that uses it.
    always_ff @(posedge clk)
    begin
        if (lbl_we)
            label_mem[lbl_waddr] <= lbl_wdata;
        lbl_rd_reg <= label_mem[addr_next];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[idx_reg] <= cnt_wdata;
        cnt_rd_reg <= cnt_mem[idx_next];
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
            size_mem[size_waddr] <= size_wdata;
        size_rd_reg <= size_mem[idx_next];
    end

    // Sequencer: next state, memory writes and result word.
    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        addr_next         = addr_reg;
        idx_next          = idx_reg;
        best_next         = best_reg;
        best_score_next   = best_score_reg;
        best_size_next    = best_size_reg;
        prod_next         = prod_reg;
        cnt_s_next        = cnt_s_reg;
        size_s_next       = size_s_reg;
        cnt_valid_next    = cnt_valid_reg;
        size_valid_next   = size_valid_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_cluster_next  = out_cluster_reg;
        out_assigned_next = out_assigned_reg;
        out_skipped_next  = out_skipped_reg;
        lbl_we            = 1'b0;
        lbl_waddr         = addr_reg;
        lbl_wdata         = '0;
        cnt_we            = 1'b0;
        cnt_wdata         = cnt_eff;
        size_we           = 1'b0;
        size_waddr        = idx_reg;
        size_wdata        = size_eff;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the label memory to unassigned after reset.
                lbl_we        = 1'b1;
                lbl_waddr     = clr_addr_reg;
                lbl_wdata     = '0;
                clr_addr_next = clr_addr_reg + VTX_W'(1);
                if (clr_addr_reg == VTX_W'(MAX_VERTICES - 1))
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    unique case (in_func)
                        FUNC_NEIGHBOUR:
                        begin
                            addr_next  = in_neighbour;
                            state_next = ST_NB_LBL;
                        end
                        FUNC_DECIDE:
                        begin
                            addr_next  = in_vertex;
                            state_next = ST_DEC_LBL;
                        end
                        FUNC_SEED:
                        begin
                            addr_next  = in_vertex;
                            idx_next   = in_seed;
                            state_next = ST_SEED;
                        end
                        FUNC_CLEAR_SIZES:
                            size_valid_next = '0;
                        FUNC_READ_LABEL:
                        begin
                            addr_next  = in_vertex;
                            state_next = ST_READ;
                        end
                        default: ;  // unknown func: drop the word
                    endcase
                end
            end

            ST_NB_LBL:
            begin
                if (lbl_rd_reg[CL_W])
                begin
                    idx_next   = lbl_rd_reg[CL_W-1:0];
                    state_next = ST_NB_CNT;
                end
                else
                    state_next = ST_IDLE;
            end

            ST_NB_CNT:
            begin
                // Raise the neighbour's cluster count, saturating.
                if (cnt_eff != '1)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_eff + CNT_W'(1);
                    cnt_valid_next[idx_reg] = 1'b1;
                end
                state_next = ST_IDLE;
            end

            ST_DEC_LBL:
            begin
                if (first_pass_reg && lbl_rd_reg[CL_W])
                begin
                    // Keep the existing label; hold until the output frees.
                    if (out_free)
                    begin
                        out_valid_next    = 1'b1;
                        out_cluster_next  = lbl_rd_reg[CL_W-1:0];
                        out_assigned_next = 1'b1;
                        out_skipped_next  = 1'b1;
                        cnt_valid_next    = '0;
                        state_next        = ST_IDLE;
                    end
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN_MUL;
                end
            end

            ST_SCAN_MUL:
            begin
                prod_next   = PROD_W'(alpha_reg) * PROD_W'(size_eff);
                cnt_s_next  = cnt_eff;
                size_s_next = size_eff;
                state_next  = ST_SCAN_CMP;
            end

            ST_SCAN_CMP:
            begin
                // Higher score wins; a tie goes to the later cluster only if smaller.
                if (idx_reg == '0 || score > best_score_reg ||
                    (score == best_score_reg && best_size_reg > size_s_reg))
                begin
                    best_next       = idx_reg;
                    best_score_next = score;
                    best_size_next  = size_s_reg;
                end
                if (idx_reg == k_last)
                    state_next = ST_DEC_WR;
                else
                begin
                    idx_next   = idx_reg + CL_W'(1);
                    state_next = ST_SCAN_MUL;
                end
            end

            ST_DEC_WR:
            begin
                if (out_free)
                begin
                    lbl_we     = 1'b1;
                    lbl_wdata  = {1'b1, best_reg};
                    size_we    = 1'b1;
                    size_waddr = best_reg;
                    size_wdata = (best_size_reg == '1) ? best_size_reg
                                                       : best_size_reg + SIZE_W'(1);
                    size_valid_next[best_reg] = 1'b1;
                    cnt_valid_next    = '0;
                    out_valid_next    = 1'b1;
                    out_cluster_next  = best_reg;
                    out_assigned_next = 1'b1;
                    out_skipped_next  = 1'b0;
                    state_next        = ST_IDLE;
                end
            end

            ST_SEED:
            begin
                lbl_we     = 1'b1;
                lbl_wdata  = {1'b1, idx_reg};
                size_we    = 1'b1;
                size_wdata = (size_eff == '1) ? size_eff : size_eff + SIZE_W'(1);
                size_valid_next[idx_reg] = 1'b1;
                state_next = ST_IDLE;
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_cluster_next  = lbl_rd_reg[CL_W] ? lbl_rd_reg[CL_W-1:0] : '0;
                    out_assigned_next = lbl_rd_reg[CL_W];
                    out_skipped_next  = 1'b0;
                    state_next        = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/sgpa_checker.sv
`include "assert_macros.svh"

module sgpa_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [sgpa_pkg::S_USER_W-1:0]   s_tuser,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [sgpa_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic [sgpa_pkg::M_USER_W-1:0]   m_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready
);
    import sgpa_pkg::*;

    // A stalled result word holds.
    `CHK_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // Neighbour words always take further cycles: ready drops after accept.
    `CHK_NEXT(a_nb_busy, clk, rst_n, s_tvalid && s_tready && s_tuser == FUNC_NEIGHBOUR, !s_tready, "ready stayed high after a neighbour word")

    // A skipped decide always reports a labelled vertex.
    `CHK_IMPLY(a_skip_assigned, clk, rst_n, m_tvalid && m_tuser[1], m_tuser[0], "skipped without assigned")

    // An unassigned vertex reports cluster zero and no pad bits.
    `CHK_IMPLY(a_unassigned_zero, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata == '0, "unassigned result with nonzero cluster")

endmodule

bind streaming_graph_partition_assign sgpa_checker u_sgpa_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
